@@ rtl/kss_pkg.sv @@
// Package for the key frame segment search block.
// Shared widths, status and register codes, and divider request/response types.
// No dependencies.
package kss_pkg;

	localparam int TIME_W = 32;
	localparam int FPS_W  = 8;
	localparam int PROD_W = TIME_W + FPS_W;
	localparam int KEY_W  = 16;
	localparam int FRAC_W = 17;
	localparam int IDX_W  = 8;
	localparam int ST_W   = 3;
	localparam int CFG_W  = 9;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	// Result status codes
	localparam logic [ST_W-1:0] ST_INSIDE   = 3'd0;
	localparam logic [ST_W-1:0] ST_PAST     = 3'd1;
	localparam logic [ST_W-1:0] ST_BEFORE   = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_LOAD     = 3'd4;

	// Request type codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_KEY_COUNT = 1'b0,
		REG_FPS       = 1'b1
	} reg_index_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] num;
		logic [KEY_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ rtl/kss_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module kss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/kss_div.sv @@
// Restoring divider for the segment fraction, one quotient bit per cycle.
// Quotient is saturated to one (Q1.16). Depends on kss_pkg.
module kss_div (
	input  logic               clk,
	input  logic               arst_n,
	input  kss_pkg::div_req_t  req,
	output kss_pkg::div_rsp_t  rsp,
	output logic               busy
);
	import kss_pkg::*;

	localparam int QW = FRAC_W + 1;

	logic              busy_q;
	logic              done_q;
	logic              sat_q;
	logic [4:0]        cnt_q;
	logic [KEY_W-1:0]  rem_q;
	logic [KEY_W-1:0]  den_q;
	logic [QW-1:0]     lo_q;
	logic [QW-1:0]     quo_q;
	logic [KEY_W:0]    trial;
	logic              ovf;

	assign trial = {rem_q, lo_q[QW-1]};
	// quotient would reach 2^18 or more: saturate right away
	assign ovf = req.num[PROD_W-1:QW] >= (PROD_W-QW)'(req.den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done pulses after a saturated start or after the last quotient bit
			done_q <= req.start ? ovf : (busy_q && cnt_q == 5'd0);
			if (req.start) begin
				sat_q <= ovf;
				cnt_q <= 5'(QW - 1);
				if (!ovf) begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[QW+KEY_W-1:QW];
			lo_q  <= req.num[QW-1:0];
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			lo_q <= {lo_q[QW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= KEY_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[KEY_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = (sat_q || quo_q > QW'(FRAC_ONE)) ? FRAC_ONE : quo_q[FRAC_W-1:0];
	assign busy     = busy_q;

endmodule

@@ rtl/keyframe_segment_search_unit.sv @@
// Key frame segment search unit. Load transactions write one key frame number into
// the key table and are acknowledged through the done state and the output register.
// A lookup runs the time-to-frame multiply (S_MUL) and the end checks (S_K0), then
// reads each key pair tried from the search hint in S_RA and S_RB (one table read
// port, two reads per pair), then divides bit-serially for the fraction in S_DIV,
// and passes the result to the output register from S_DONE once that is free.
// The block takes one transaction at a time; a finished result waits in the output
// register while the next transaction is accepted.
module keyframe_segment_search_unit #(
	parameter int MAX_KEYS   = 256,
	parameter int FRAME_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [kss_pkg::CFG_W-1:0]   cfg_data,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [kss_pkg::IDX_W-1:0]   key_index,
	input  logic [kss_pkg::KEY_W-1:0]   key_frame,
	input  logic [kss_pkg::TIME_W-1:0]  time_q16,
	input  logic                        forwards,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kss_pkg::IDX_W-1:0]   first_index,
	output logic [kss_pkg::IDX_W-1:0]   second_index,
	output logic [kss_pkg::FRAC_W-1:0]  fraction_q16,
	output logic [kss_pkg::ST_W-1:0]    status
);
	import kss_pkg::*;

	localparam int IW = $clog2(MAX_KEYS);
	localparam int NW = IW + 1;
	localparam int CW = (NW > 9) ? NW : 9;
	localparam int EW = (FRAME_BITS > 24) ? FRAME_BITS : 24;
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_KEYS);
	localparam logic [EW-1:0] FMAX_E = EW'((64'd1 << FRAME_BITS) - 64'd1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_K0   = 7'b0000100,
		S_RA   = 7'b0001000,
		S_RB   = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  kc_q;
	logic [FPS_W-1:0]  fps_q;
	logic [IDX_W-1:0]  hint_q;
	logic [TIME_W-1:0] t_q;
	logic              fwd_q;
	logic [PROD_W-1:0] prod_q;
	logic [KEY_W-1:0]  klast_q;
	logic [KEY_W-1:0]  f1_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     step_q;
	logic [CW-1:0]     n_q;
	logic [IDX_W-1:0]  res_first_q;
	logic [IDX_W-1:0]  res_second_q;
	logic [FRAC_W-1:0] res_frac_q;
	logic [ST_W-1:0]   res_st_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  second_q;
	logic [FRAC_W-1:0] frac_q;
	logic [ST_W-1:0]   st_q;

	logic [CW-1:0]     kc_e;
	logic [CW-1:0]     n_c;
	logic [CW-1:0]     start_c;
	logic [CW-1:0]     inext_c;
	logic [CW-1:0]     rd_addr_c;
	logic [CW-1:0]     kidx_e;
	logic [EW-1:0]     frame_e;
	logic [EW-1:0]     frame_c;
	logic [KEY_W-1:0]  rd_data;
	logic              ram_we;
	logic              match_c;
	logic [PROD_W-1:0] base_c;
	logic              accept;
	logic              out_free;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic              div_busy;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// clamp of the key count to the table
	assign kc_e = CW'(kc_q);
	always_comb begin
		if (kc_e < CW'(2)) begin
			n_c = CW'(2);
		end else if (kc_e > MAX_C) begin
			n_c = MAX_C;
		end else begin
			n_c = kc_e;
		end
	end

	// frame number, saturated
	assign frame_e = EW'(prod_q[PROD_W-1:16]);
	assign frame_c = (frame_e > FMAX_E) ? FMAX_E : frame_e;

	// search start and next pair
	always_comb begin
		if (hint_q != '0 && CW'(hint_q) < n_q - CW'(1)) begin
			start_c = CW'(hint_q) + CW'(1);
		end else begin
			start_c = CW'(1);
		end
		if (fwd_q) begin
			inext_c = (i_q + CW'(1) >= n_q) ? CW'(1) : i_q + CW'(1);
		end else begin
			inext_c = (i_q <= CW'(1)) ? n_q - CW'(1) : i_q - CW'(1);
		end
	end

	assign match_c = (frame_c <= EW'(rd_data)) && (frame_c >= EW'(f1_q));
	assign base_c  = PROD_W'({f1_q, 16'h0000});

	// table read address per step
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr_c = n_c - CW'(1);
			S_MUL:   rd_addr_c = '0;
			S_K0:    rd_addr_c = start_c - CW'(1);
			S_RA:    rd_addr_c = i_q;
			S_RB:    rd_addr_c = inext_c - CW'(1);
			default: rd_addr_c = '0;
		endcase
	end

	assign kidx_e = CW'(key_index);
	assign ram_we = accept && req_type == REQ_LOAD && kidx_e < MAX_C;

	// fraction divide request
	always_comb begin
		div_req.start = (state_q == S_RB) && match_c && (rd_data > f1_q);
		div_req.num   = (prod_q > base_c) ? prod_q - base_c : '0;
		div_req.den   = rd_data - f1_q;
	end

	kss_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_KEYS)
	) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (kidx_e[IW-1:0]),
		.wdata (key_frame),
		.raddr (rd_addr_c[IW-1:0]),
		.rdata (rd_data)
	);

	kss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp),
		.busy   (div_busy)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q  <= CFG_W'(2);
			fps_q <= 8'd30;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_KEY_COUNT: kc_q  <= cfg_data;
				REG_FPS:       fps_q <= cfg_data[FPS_W-1:0];
				default:       ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set when a result moves out, cleared when taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (req_type == REQ_LOAD) ? S_DONE : S_MUL;
					end
				end
				S_MUL: state_q <= S_K0;
				S_K0: begin
					if (frame_c > EW'(klast_q)) begin
						hint_q  <= IDX_W'(n_q - CW'(1));
						state_q <= S_DONE;
					end else if (frame_c < EW'(rd_data)) begin
						hint_q  <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RA;
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: begin
					if (match_c) begin
						hint_q  <= IDX_W'(i_q - CW'(1));
						state_q <= (rd_data > f1_q) ? S_DIV : S_DONE;
					end else if (step_q == n_q - CW'(2)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RA;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q          <= time_q16;
				fwd_q        <= forwards;
				n_q          <= n_c;
				res_first_q  <= '0;
				res_second_q <= '0;
				res_frac_q   <= '0;
				res_st_q     <= ST_LOAD;
			end
			S_MUL: begin
				prod_q  <= t_q * PROD_W'(fps_q);
				klast_q <= rd_data;
			end
			S_K0: begin
				i_q    <= start_c;
				step_q <= '0;
				if (frame_c > EW'(klast_q)) begin
					res_first_q  <= IDX_W'(n_q - CW'(1));
					res_second_q <= IDX_W'(n_q - CW'(1));
					res_st_q     <= ST_PAST;
				end else begin
					res_st_q <= ST_BEFORE;
				end
			end
			S_RA: f1_q <= rd_data;
			S_RB: begin
				i_q    <= inext_c;
				step_q <= step_q + CW'(1);
				if (match_c) begin
					res_first_q  <= IDX_W'(i_q - CW'(1));
					res_second_q <= IDX_W'(i_q);
					res_st_q     <= ST_INSIDE;
				end else begin
					res_st_q <= ST_NOTFOUND;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					res_frac_q <= div_rsp.quot;
				end
			end
			S_DONE: begin
				if (out_free) begin
					first_q  <= res_first_q;
					second_q <= res_second_q;
					frac_q   <= res_frac_q;
					st_q     <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign first_index  = first_q;
	assign second_index = second_q;
	assign fraction_q16 = frac_q;
	assign status       = st_q;

	// an inside result always names adjacent keys
	a_inside_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_INSIDE |-> second_index == first_index + 8'd1)
		else $error("inside result with non-adjacent indices");

	// boundary, load and not-found results carry no fraction
	a_frac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_INSIDE |-> fraction_q16 == '0)
		else $error("fraction set on non-inside result");

	// fraction never exceeds one
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fraction_q16 <= FRAC_ONE)
		else $error("fraction above one");

	// divider only runs while the sequencer waits on it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DIV |-> !div_busy)
		else $error("divider busy outside divide step");

endmodule
